@@ sv/rcpb_pkg.sv @@
// Shared types, constants and control store for the RMAP command packet builder.
// Holds request/result payload structs, config register indexes, CRC-8 and microcode.
// No dependencies.
package rcpb_pkg;

  localparam int unsigned MAX_PATH_BYTES = 12;
  localparam int unsigned STEP_W         = 5;
  localparam int unsigned CFG_INDEX_W    = 3;
  localparam int unsigned CFG_DATA_W     = 64;

  localparam logic [STEP_W-1:0] STEP_LAST = 5'd23;

  localparam logic [7:0] PROTOCOL_ID   = 8'h01;
  localparam logic [7:0] INSTR_COMMAND = 8'h40;
  localparam logic [7:0] INSTR_WRITE   = 8'h20;
  localparam logic [7:0] CRC_POLY_REFL = 8'hE0;
  localparam logic [7:0] WRITE_LENGTH  = 8'h04;
  localparam logic [23:0] NODE_ADDR_RESET = 24'hFEFEFE;

  localparam logic [CFG_INDEX_W-1:0] REG_NODE_ADDRESSING = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_PATH_LENGTH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IN_PATH_LENGTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_PATH_LOW    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_PATH_HIGH   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_IN_PATH_LOW     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_IN_PATH_HIGH    = 3'd6;

  typedef struct packed {
    logic        mode;
    logic [2:0]  option_flags;
    logic [15:0] transaction_id;
    logic [31:0] target_address;
    logic [23:0] read_length;
    logic [31:0] write_word;
  } rcpb_in_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } rcpb_out_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef enum logic [4:0] {
    SRC_OUT_PATH,
    SRC_DEST_LA,
    SRC_PROTO,
    SRC_INSTR,
    SRC_KEY,
    SRC_ZERO,
    SRC_IN_PATH,
    SRC_SRC_LA,
    SRC_TID_HI,
    SRC_TID_LO,
    SRC_ADDR3,
    SRC_ADDR2,
    SRC_ADDR1,
    SRC_ADDR0,
    SRC_LEN2,
    SRC_LEN1,
    SRC_LEN0,
    SRC_CRC,
    SRC_DATA0,
    SRC_DATA1,
    SRC_DATA2,
    SRC_DATA3
  } byte_src_t;

  typedef enum logic [1:0] {
    LOOP_NONE,
    LOOP_OUT,
    LOOP_PAD,
    LOOP_IN
  } loop_t;

  typedef struct packed {
    byte_src_t src;
    logic      crc_en;
    logic      crc_clear;
    loop_t     loop;
    logic      end_if_read;
    logic      last;
  } ucode_t;

  function automatic ucode_t uc(input byte_src_t src, input logic crc_en,
                                input logic crc_clear, input loop_t loop,
                                input logic end_if_read, input logic last);
    ucode_t w;
    w.src         = src;
    w.crc_en      = crc_en;
    w.crc_clear   = crc_clear;
    w.loop        = loop;
    w.end_if_read = end_if_read;
    w.last        = last;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      5'd0:    w = uc(SRC_OUT_PATH, 1'b0, 1'b0, LOOP_OUT,  1'b0, 1'b0);
      5'd1:    w = uc(SRC_DEST_LA,  1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd2:    w = uc(SRC_PROTO,    1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd3:    w = uc(SRC_INSTR,    1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd4:    w = uc(SRC_KEY,      1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd5:    w = uc(SRC_ZERO,     1'b1, 1'b0, LOOP_PAD,  1'b0, 1'b0);
      5'd6:    w = uc(SRC_IN_PATH,  1'b1, 1'b0, LOOP_IN,   1'b0, 1'b0);
      5'd7:    w = uc(SRC_SRC_LA,   1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd8:    w = uc(SRC_TID_HI,   1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd9:    w = uc(SRC_TID_LO,   1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd10:   w = uc(SRC_ZERO,     1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd11:   w = uc(SRC_ADDR3,    1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd12:   w = uc(SRC_ADDR2,    1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd13:   w = uc(SRC_ADDR1,    1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd14:   w = uc(SRC_ADDR0,    1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd15:   w = uc(SRC_LEN2,     1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd16:   w = uc(SRC_LEN1,     1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd17:   w = uc(SRC_LEN0,     1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd18:   w = uc(SRC_CRC,      1'b0, 1'b1, LOOP_NONE, 1'b1, 1'b0);
      5'd19:   w = uc(SRC_DATA0,    1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd20:   w = uc(SRC_DATA1,    1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd21:   w = uc(SRC_DATA2,    1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd22:   w = uc(SRC_DATA3,    1'b1, 1'b0, LOOP_NONE, 1'b0, 1'b0);
      5'd23:   w = uc(SRC_CRC,      1'b0, 1'b1, LOOP_NONE, 1'b0, 1'b1);
      default: w = uc(SRC_CRC,      1'b0, 1'b1, LOOP_NONE, 1'b0, 1'b1);
    endcase
    return w;
  endfunction

  // RMAP CRC-8, reflected x^8+x^2+x+1
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ sv/rmap_command_packet_builder_core.sv @@
// RMAP command packet builder top level: config registers, microcoded byte sequencer.
// Depends on rcpb_pkg (payload structs, register indexes, control store, CRC-8).
//
// Usage: a request on in_valid/in_ready (struct rcpb_in_t) becomes one RMAP command
// packet, delivered one byte per result on out_valid/out_ready (struct rcpb_out_t),
// with last_byte set on the final byte. Configuration registers (node addressing,
// path lengths, path bytes) are written through cfg_valid/cfg_ready/cfg_index/
// cfg_data; cfg_ready is always high. Writes are to be made only while idle; the
// block itself does not enforce it. Start: an accepted request puts the sequencer
// in its run state, and the first byte is then registered into the output register;
// with no destination path the sequencer first steps past the empty path loop.
// Throughput: one byte per cycle while the receiver does not stall, except where
// each of the three path loops (destination path, source pad, source path) closes
// and no byte is sent. The longest write packet has 45 bytes. The next request is
// accepted once the sequencer is back in idle after the packet's last byte is
// registered. The step counter walks the control store.
// Reset: registers return to their reset values, the sequencer is idle and no
// result is pending. When the receiver stalls, the sequencer holds its step (it
// still steps past a finished path loop) until the output register is free again.
module rmap_command_packet_builder_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rcpb_pkg::rcpb_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rcpb_pkg::rcpb_out_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rcpb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rcpb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [23:0] node_addressing;
  logic [3:0]  out_path_length;
  logic [3:0]  in_path_length;
  logic [63:0] out_path_low;
  logic [31:0] out_path_high;
  logic [63:0] in_path_low;
  logic [31:0] in_path_high;

  rcpb_pkg::seq_state_t state, state_next;
  logic [rcpb_pkg::STEP_W-1:0] step;
  logic [3:0]  cnt;
  logic [7:0]  crc;
  logic [31:0] held_address;
  logic [31:0] held_payload;
  logic        held_mode;
  logic [2:0]  held_flags;
  logic [15:0] held_tid;

  rcpb_pkg::ucode_t uw;
  logic [3:0]  out_len;
  logic [3:0]  in_len;
  logic [1:0]  in_words;
  logic [1:0]  pad_len;
  logic [3:0]  loop_count;
  logic        loop_done;
  logic        emit;
  logic        finish;
  logic        in_fire;
  logic [7:0]  tx_byte;
  logic [95:0] out_path_vec;
  logic [95:0] in_path_vec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_addressing <= rcpb_pkg::NODE_ADDR_RESET;
      out_path_length <= '0;
      in_path_length  <= '0;
      out_path_low    <= '0;
      out_path_high   <= '0;
      in_path_low     <= '0;
      in_path_high    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rcpb_pkg::REG_NODE_ADDRESSING: node_addressing <= cfg_data[23:0];
        rcpb_pkg::REG_OUT_PATH_LENGTH: out_path_length <= cfg_data[3:0];
        rcpb_pkg::REG_IN_PATH_LENGTH:  in_path_length  <= cfg_data[3:0];
        rcpb_pkg::REG_OUT_PATH_LOW:    out_path_low    <= cfg_data;
        rcpb_pkg::REG_OUT_PATH_HIGH:   out_path_high   <= cfg_data[31:0];
        rcpb_pkg::REG_IN_PATH_LOW:     in_path_low     <= cfg_data;
        rcpb_pkg::REG_IN_PATH_HIGH:    in_path_high    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign out_len  = (out_path_length > 4'(rcpb_pkg::MAX_PATH_BYTES)) ?
                    4'(rcpb_pkg::MAX_PATH_BYTES) : out_path_length;
  assign in_len   = (in_path_length > 4'(rcpb_pkg::MAX_PATH_BYTES)) ?
                    4'(rcpb_pkg::MAX_PATH_BYTES) : in_path_length;
  assign in_words = 2'(({1'b0, in_len} + 5'd3) >> 2);
  assign pad_len  = 2'(3'd4 - {1'b0, in_len[1:0]});

  assign out_path_vec = {out_path_high, out_path_low};
  assign in_path_vec  = {in_path_high, in_path_low};

  assign uw = rcpb_pkg::ucode_rom(step);

  always_comb begin
    unique case (uw.loop)
      rcpb_pkg::LOOP_NONE: loop_count = 4'd0;
      rcpb_pkg::LOOP_OUT:  loop_count = out_len;
      rcpb_pkg::LOOP_PAD:  loop_count = {2'b00, pad_len};
      rcpb_pkg::LOOP_IN:   loop_count = in_len;
      default:             loop_count = 4'd0;
    endcase
  end

  assign in_fire   = in_valid && in_ready;
  assign loop_done = (uw.loop != rcpb_pkg::LOOP_NONE) && (cnt == loop_count);
  assign emit      = (state == rcpb_pkg::SEQ_RUN) && !loop_done && (!out_valid || out_ready);
  assign finish    = emit && (uw.last || (uw.end_if_read && !held_mode));

  always_comb begin
    unique case (uw.src)
      rcpb_pkg::SRC_OUT_PATH: tx_byte = out_path_vec[{cnt, 3'b000} +: 8];
      rcpb_pkg::SRC_DEST_LA:  tx_byte = node_addressing[7:0];
      rcpb_pkg::SRC_PROTO:    tx_byte = rcpb_pkg::PROTOCOL_ID;
      rcpb_pkg::SRC_INSTR:    tx_byte = rcpb_pkg::INSTR_COMMAND
                                        | (held_mode ? rcpb_pkg::INSTR_WRITE : 8'h00)
                                        | {3'b000, held_flags, in_words};
      rcpb_pkg::SRC_KEY:      tx_byte = node_addressing[23:16];
      rcpb_pkg::SRC_ZERO:     tx_byte = 8'h00;
      rcpb_pkg::SRC_IN_PATH:  tx_byte = in_path_vec[{cnt, 3'b000} +: 8];
      rcpb_pkg::SRC_SRC_LA:   tx_byte = node_addressing[15:8];
      rcpb_pkg::SRC_TID_HI:   tx_byte = held_tid[15:8];
      rcpb_pkg::SRC_TID_LO:   tx_byte = held_tid[7:0];
      rcpb_pkg::SRC_ADDR3:    tx_byte = held_address[31:24];
      rcpb_pkg::SRC_ADDR2:    tx_byte = held_address[23:16];
      rcpb_pkg::SRC_ADDR1:    tx_byte = held_address[15:8];
      rcpb_pkg::SRC_ADDR0:    tx_byte = held_address[7:0];
      rcpb_pkg::SRC_LEN2:     tx_byte = held_mode ? 8'h00 : held_payload[23:16];
      rcpb_pkg::SRC_LEN1:     tx_byte = held_mode ? 8'h00 : held_payload[15:8];
      rcpb_pkg::SRC_LEN0:     tx_byte = held_mode ? rcpb_pkg::WRITE_LENGTH
                                                  : held_payload[7:0];
      rcpb_pkg::SRC_CRC:      tx_byte = crc;
      rcpb_pkg::SRC_DATA0:    tx_byte = held_payload[7:0];
      rcpb_pkg::SRC_DATA1:    tx_byte = held_payload[15:8];
      rcpb_pkg::SRC_DATA2:    tx_byte = held_payload[23:16];
      rcpb_pkg::SRC_DATA3:    tx_byte = held_payload[31:24];
      default:                tx_byte = 8'h00;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rcpb_pkg::SEQ_IDLE: if (in_valid) state_next = rcpb_pkg::SEQ_RUN;
      rcpb_pkg::SEQ_RUN:  if (finish) state_next = rcpb_pkg::SEQ_IDLE;
      default:            state_next = rcpb_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == rcpb_pkg::SEQ_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rcpb_pkg::SEQ_IDLE;
      step         <= '0;
      cnt          <= '0;
      crc          <= '0;
      out_valid    <= 1'b0;
      held_address <= '0;
      held_payload <= '0;
      held_mode    <= 1'b0;
      held_flags   <= '0;
      held_tid     <= '0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        held_address <= in_data.target_address;
        held_payload <= in_data.mode ? in_data.write_word : {8'h00, in_data.read_length};
        held_mode    <= in_data.mode;
        held_flags   <= in_data.option_flags;
        held_tid     <= in_data.transaction_id;
        step         <= '0;
        cnt          <= '0;
        crc          <= '0;
      end else if (state == rcpb_pkg::SEQ_RUN) begin
        if (loop_done) begin
          cnt  <= '0;
          step <= step + 1'b1;
        end else if (emit) begin
          if (uw.crc_clear) begin
            crc <= '0;
          end else if (uw.crc_en) begin
            crc <= rcpb_pkg::crc_byte(crc, tx_byte);
          end
          if (finish) begin
            step <= '0;
            cnt  <= '0;
          end else if (uw.loop != rcpb_pkg::LOOP_NONE) begin
            cnt <= cnt + 1'b1;
          end else begin
            step <= step + 1'b1;
          end
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.packet_byte <= tx_byte;
      out_data.last_byte   <= finish;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == rcpb_pkg::SEQ_RUN) |-> (step <= rcpb_pkg::STEP_LAST))
    else $error("sequencer step out of range");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= 4'(rcpb_pkg::MAX_PATH_BYTES))
    else $error("path loop counter out of range");

  a_idle_crc: assert property (@(posedge clk) disable iff (rst)
    (state == rcpb_pkg::SEQ_IDLE) |-> (crc == 8'h00 && step == '0))
    else $error("sequencer not cleared while idle");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    finish |=> (state == rcpb_pkg::SEQ_IDLE && out_valid && out_data.last_byte))
    else $error("packet end not followed by idle with last byte");

endmodule
